// ===== hw/rtl/bmt_pkg.sv =====
// ----------------------------------------------------------------------------
// Breakpoint match table package
// Item codes, entry kinds, status codes and field widths of the table.
// ----------------------------------------------------------------------------
package bmt_pkg;

  localparam int FUNC_W    = 16;
  localparam int OFFS_W    = 16;
  localparam int CHAIN_W   = 16;
  localparam int DEPTH_W   = 10;
  localparam int ID_W      = 16;
  localparam int KIND_W    = 3;
  // One more bit than an id, so the counter can stop at its limit.
  localparam int IDCNT_W   = ID_W + 1;
  localparam int S_TDATA_W = 80;
  localparam int M_TDATA_W = 40;

  // Item codes carried on the input tuser.
  localparam logic [KIND_W-1:0] KIND_CHECK        = 3'd0;
  localparam logic [KIND_W-1:0] KIND_ADD_LOCATION = 3'd1;
  localparam logic [KIND_W-1:0] KIND_ADD_ANYWHERE = 3'd2;
  localparam logic [KIND_W-1:0] KIND_ADD_STEPOVER = 3'd3;
  localparam logic [KIND_W-1:0] KIND_ADD_FINISH   = 3'd4;
  localparam logic [KIND_W-1:0] KIND_REMOVE       = 3'd5;

  typedef enum logic [1:0] {
    ENT_LOCATION = 2'd0,
    ENT_ANYWHERE = 2'd1,
    ENT_STEPOVER = 2'd2,
    ENT_FINISH   = 2'd3
  } entry_kind_t;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_FULL      = 2'd1,
    STATUS_EXHAUSTED = 2'd2,
    STATUS_NOT_FOUND = 2'd3
  } status_t;

endpackage

// ===== hw/rtl/breakpoint_match_table_unit.sv =====
// ----------------------------------------------------------------------------
// Breakpoint match table unit
// Stores breakpoints and checks execution frames against all of them at once.
// ----------------------------------------------------------------------------
// Usage:
// Each input item on the s_ channel is one command, selected by s_tuser: check
// a frame, add a location, anywhere, step-over or finish breakpoint, or remove
// breakpoints by id. Every item produces exactly one result item on the m_
// channel with the hit flag, the id of the newest matching entry, the id given
// to an added entry and a status code.
// An accepted item waits in the input register while the table is read; when
// the output register can accept, the table is updated and the result is
// written to the output register. The result is therefore registered, and a new
// item can be taken every cycle while the receiver does not stall. Each item
// sees the table as left by the previous one, since the update lands before the
// next item's lookup.
// The newest match is chosen through an age matrix that records, for every
// pair of entries, which one was added later, so no id comparison chain is
// needed. Reset empties the table, restarts ids at zero and drops both
// pipeline registers. When the receiver stalls, the result is held and the
// input register keeps its item; s_tready stays high while that register is
// empty, so one more item is still accepted during a stall.
module breakpoint_match_table_unit
  import bmt_pkg::*;
#(
  parameter int ENTRIES = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // function_id[15:0], code_offset[31:16], frame_chain[47:32],
  // frame_depth[57:48], once_flag[58], target_id[74:59], zero fill above.
  input  logic [S_TDATA_W-1:0] s_tdata,
  // kind[2:0].
  input  logic [KIND_W-1:0]    s_tuser,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // hit[0], hit_id[16:1], new_id[32:17], status[34:33], zero fill above.
  output logic [M_TDATA_W-1:0] m_tdata
);

  // Input register.
  logic                in_valid;
  logic [KIND_W-1:0]   in_kind;
  logic [FUNC_W-1:0]   in_func;
  logic [OFFS_W-1:0]   in_offs;
  logic [CHAIN_W-1:0]  in_chain;
  logic [DEPTH_W-1:0]  in_depth;
  logic                in_once;
  logic [ID_W-1:0]     in_target;

  // Table storage. Only entry_valid is reset; the rest is read for valid
  // entries only, which are always written first.
  logic [ENTRIES-1:0]  entry_valid;
  logic [ENTRIES-1:0]  entry_valid_next;
  entry_kind_t         entry_kind     [ENTRIES];
  logic [ENTRIES-1:0]  entry_once;
  logic [FUNC_W-1:0]   entry_function [ENTRIES];
  logic [OFFS_W-1:0]   entry_offset   [ENTRIES];
  logic [CHAIN_W-1:0]  entry_chain    [ENTRIES];
  logic [DEPTH_W-1:0]  entry_depth    [ENTRIES];
  logic [ID_W-1:0]     entry_ident    [ENTRIES];
  // newer[i][j] is set when entry j was added after entry i.
  logic [ENTRIES-1:0]  newer          [ENTRIES];
  logic [IDCNT_W-1:0]  next_ident;

  // Result register.
  logic                out_hit;
  logic [ID_W-1:0]     out_hit_id;
  logic [ID_W-1:0]     out_new_id;
  status_t             out_status;

  logic                advance;
  logic                process;
  logic                is_check;
  logic                is_add;
  logic                is_remove;
  logic                add_ok;
  logic [ENTRIES-1:0]  match;
  logic [ENTRIES-1:0]  win;
  logic [ENTRIES-1:0]  id_hit;
  logic [ENTRIES-1:0]  free;
  logic [ENTRIES-1:0]  alloc;
  logic [ID_W-1:0]     hit_id;
  logic [KIND_W-1:0]   kind_minus_one;
  entry_kind_t         add_kind;
  logic                add_once;
  status_t             status;

  // The result register frees up when empty or taken; the input register
  // moves on whenever the result register can accept.
  assign advance  = !m_tvalid || m_tready;
  assign process  = in_valid && advance;
  assign s_tready = !in_valid || advance;

  assign is_check  = (in_kind == KIND_CHECK);
  assign is_add    = (in_kind == KIND_ADD_LOCATION) || (in_kind == KIND_ADD_ANYWHERE) ||
                     (in_kind == KIND_ADD_STEPOVER) || (in_kind == KIND_ADD_FINISH);
  assign is_remove = (in_kind == KIND_REMOVE);

  // Per-entry frame match and remove match, all entries in parallel.
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      case (entry_kind[i])
        ENT_LOCATION: match[i] = (entry_function[i] == in_func) &&
                                 (entry_offset[i] == in_offs);
        ENT_ANYWHERE: match[i] = 1'b1;
        ENT_STEPOVER: match[i] = ((in_chain == entry_chain[i]) &&
                                  (in_depth <= entry_depth[i])) ||
                                 (in_chain < entry_chain[i]);
        default:      match[i] = ((in_chain == entry_chain[i]) &&
                                  (in_depth < entry_depth[i])) ||
                                 (in_chain < entry_chain[i]);
      endcase
      match[i]  = match[i] && entry_valid[i];
      id_hit[i] = entry_valid[i] && (entry_ident[i] == in_target);
    end
  end

  // The newest match is the one that no other match is newer than.
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      win[i] = match[i] && !(|(match & newer[i]));
    end
  end

  always_comb begin
    hit_id = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_id = hit_id | (win[i] ? entry_ident[i] : '0);
    end
  end

  // Lowest free slot as a one-hot vector.
  assign free  = ~entry_valid;
  assign alloc = free & (~free + {{(ENTRIES-1){1'b0}}, 1'b1});

  assign kind_minus_one = in_kind - KIND_ADD_LOCATION;
  assign add_kind       = entry_kind_t'(kind_minus_one[1:0]);
  assign add_once       = (in_kind == KIND_ADD_LOCATION) ? in_once : 1'b1;
  assign add_ok         = is_add && (|free) && !next_ident[IDCNT_W-1];

  always_comb begin
    status = STATUS_OK;
    if (is_add && !(|free)) begin
      status = STATUS_FULL;
    end else if (is_add && next_ident[IDCNT_W-1]) begin
      status = STATUS_EXHAUSTED;
    end else if (is_remove && !(|id_hit)) begin
      status = STATUS_NOT_FOUND;
    end
  end

  always_comb begin
    entry_valid_next = entry_valid;
    if (is_check) begin
      entry_valid_next = entry_valid & ~(match & entry_once);
    end else if (add_ok) begin
      entry_valid_next = entry_valid | alloc;
    end else if (is_remove) begin
      entry_valid_next = entry_valid & ~id_hit;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid    <= 1'b0;
      m_tvalid    <= 1'b0;
      entry_valid <= '0;
      next_ident  <= '0;
    end else begin
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (advance) begin
        m_tvalid <= in_valid;
      end
      if (process) begin
        entry_valid <= entry_valid_next;
        if (add_ok) begin
          next_ident <= next_ident + {{(IDCNT_W-1){1'b0}}, 1'b1};
        end
      end
    end
  end

  // Input payload register.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_kind   <= s_tuser;
      in_func   <= s_tdata[15:0];
      in_offs   <= s_tdata[31:16];
      in_chain  <= s_tdata[47:32];
      in_depth  <= s_tdata[57:48];
      in_once   <= s_tdata[58];
      in_target <= s_tdata[74:59];
    end
  end

  // Entry payload and age matrix.
  always_ff @(posedge clk) begin
    if (process && add_ok) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (alloc[i]) begin
          entry_kind[i]     <= add_kind;
          entry_once[i]     <= add_once;
          entry_function[i] <= in_func;
          entry_offset[i]   <= in_offs;
          entry_chain[i]    <= in_chain;
          entry_depth[i]    <= in_depth;
          entry_ident[i]    <= next_ident[ID_W-1:0];
        end
        for (int j = 0; j < ENTRIES; j++) begin
          if (alloc[i]) begin
            newer[i][j] <= 1'b0;
          end else if (alloc[j]) begin
            newer[i][j] <= 1'b1;
          end
        end
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (advance) begin
      out_hit    <= is_check && (|match);
      out_hit_id <= is_check ? hit_id : '0;
      out_new_id <= add_ok ? next_ident[ID_W-1:0] : '0;
      out_status <= status;
    end
  end

  assign m_tdata = {{(M_TDATA_W-2-2*ID_W-1){1'b0}}, out_status, out_new_id, out_hit_id,
                    out_hit};

`ifndef SYNTH
  // At most one entry can be the newest match.
  a_single_winner: assert property (@(posedge clk) disable iff (rst)
    in_valid && is_check |-> $onehot0(win))
    else $error("more than one newest match");

  // The id counter never goes backwards.
  a_ident_monotonic: assert property (@(posedge clk) disable iff (rst)
    !rst |=> next_ident >= $past(next_ident))
    else $error("id counter decreased");

  // A successful add sets exactly one more valid entry.
  a_add_one_entry: assert property (@(posedge clk) disable iff (rst)
    process && add_ok |=> $countones(entry_valid) == $countones($past(entry_valid)) + 1)
    else $error("add did not occupy exactly one entry");

  // A result with a hit never carries a new id or an error.
  a_hit_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_hit |-> out_new_id == '0 && out_status == STATUS_OK)
    else $error("hit result carries add or error fields");

  // After reset the output channel is empty.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid && !in_valid)
    else $error("pipeline not empty after reset");
`endif

endmodule
